FILE: design/ant_pkg.sv
`default_nettype none

package ant_pkg;

  // table geometry; one slot is never counted, so the count fits the index width
  localparam int TableSlots = 16;
  localparam int IdxW       = $clog2(TableSlots);
  localparam int CntW       = IdxW;

  typedef logic [IdxW-1:0] idx_t;
  typedef logic [CntW-1:0] cnt_t;

  localparam cnt_t CountMax = CntW'(TableSlots - 1);

  // opcodes carried on in_tuser
  localparam logic [1:0] OP_MESSAGE = 2'd0;
  localparam logic [1:0] OP_PURGE   = 2'd1;
  localparam logic [1:0] OP_CLEAR   = 2'd2;

  // configuration registers
  localparam int CfgIdxW = 8;
  localparam logic [CfgIdxW-1:0] REG_DIST_CUTOFF = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_AGE_LIMIT   = 8'd1;

  localparam logic [7:0]  DIST_CUTOFF_RST = 8'd255;
  localparam logic [31:0] AGE_LIMIT_RST   = 32'd248;

  typedef struct packed {
    logic [15:0] id;
    logic [31:0] stamp;
    logic [7:0]  distance;
    logic [7:0]  kind;
  } entry_t;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [15:0] sender_id;
    logic [7:0]  distance;
    logic [7:0]  msg_kind;
    logic [31:0] now_ticks;
  } item_t;

  typedef struct packed {
    logic   en;
    idx_t   addr;
    entry_t data;
  } ram_wr_t;

  typedef enum logic {
    CMP_ID_EQ,
    CMP_AGE_GT
  } cmp_mode_t;

  typedef struct packed {
    cmp_mode_t   mode;
    logic [31:0] a;
    logic [31:0] b;
  } cmp_req_t;

  typedef struct packed {
    logic [3:0] neighbor_count;
    logic       stored;
    logic [3:0] removed;
  } result_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MSG_RD,
    ST_MSG_CMP,
    ST_PRG_RD,
    ST_PRG_CMP,
    ST_PRG_MOVE,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

FILE: design/aging_neighbor_table.sv
// Clear, unused opcode and over-cutoff message go from idle straight to the finish state.
// Message: a read and a compare state per entry searched; an id hit rewrites it, a miss appends or drops.
// Purge: a read and a compare state per entry checked, a move state per aged entry refilled from the last.
// One item at a time; the entry RAM's single read port and the shared compare set the pace.
// Reset (rst_n low, synchronous): count 0, cutoff 255, age limit 248; RAM contents kept,
// since only entries below the count are ever read.
`default_nettype none

module aging_neighbor_table (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input item stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [63:0] in_tdata,   // sender_id[15:0], distance[23:16],
                                       // msg_kind[31:24], now_ticks[63:32]
  input  wire logic [1:0]  in_tuser,   // opcode[1:0]
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [7:0]       out_tdata,  // neighbor_count[3:0], removed[7:4]
  output logic             out_tuser,  // stored[0]
  // config writes
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  logic [7:0]        dist_cutoff_r;
  logic [31:0]       age_limit_r;
  ant_pkg::item_t    item;
  logic              seq_idle;
  ant_pkg::ram_wr_t  ram_wr;
  ant_pkg::idx_t     ram_rd_addr;
  ant_pkg::entry_t   ram_rd_data;
  ant_pkg::cmp_req_t cmp_req;
  logic              cmp_hit;
  logic              fin_valid;
  logic              fin_take;
  ant_pkg::result_t  result;
  ant_pkg::result_t  out_res_r;
  logic              out_valid_r;

  // config: always ready, writes land only while idle by contract
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dist_cutoff_r <= ant_pkg::DIST_CUTOFF_RST;
      age_limit_r   <= ant_pkg::AGE_LIMIT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == ant_pkg::REG_DIST_CUTOFF) begin
        dist_cutoff_r <= cfg_data[7:0];
      end else if (cfg_index == ant_pkg::REG_AGE_LIMIT) begin
        age_limit_r <= cfg_data;
      end
    end
  end

  // unpack the input transfer
  assign item = '{opcode:    in_tuser,
                  sender_id: in_tdata[15:0],
                  distance:  in_tdata[23:16],
                  msg_kind:  in_tdata[31:24],
                  now_ticks: in_tdata[63:32]};

  assign in_tready = seq_idle;

  ant_seq u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_tvalid && seq_idle),
    .item_in     (item),
    .dist_cutoff (dist_cutoff_r),
    .idle        (seq_idle),
    .ram_wr      (ram_wr),
    .ram_rd_addr (ram_rd_addr),
    .ram_rd_data (ram_rd_data),
    .cmp_req     (cmp_req),
    .cmp_hit     (cmp_hit),
    .fin_valid   (fin_valid),
    .fin_take    (fin_take),
    .result      (result)
  );

  ant_entry_ram u_ram (
    .clk     (clk),
    .wr      (ram_wr),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

  // shared compare: id match during search, age test during purge
  ant_cmp_unit u_cmp (
    .req       (cmp_req),
    .age_limit (age_limit_r),
    .hit       (cmp_hit)
  );

  // output register decouples the result from the sequencer
  assign fin_take = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fin_take) begin
      out_valid_r <= fin_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fin_valid && fin_take) begin
      out_res_r <= result;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_res_r.removed, out_res_r.neighbor_count};
  assign out_tuser  = out_res_r.stored;

  // an accepted item leaves the block busy in the next cycle
  a_busy_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> !in_tready)
    else $error("input taken again right after a transfer");

  // a stored message never reports removals
  a_stored_no_removed : assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tdata[7:4] == 4'd0)
    else $error("stored and removed both set");

  // age limit write takes effect on the next cycle
  a_age_limit_write : assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready && (cfg_index == ant_pkg::REG_AGE_LIMIT)
    |=> age_limit_r == $past(cfg_data))
    else $error("age limit write lost");

  // results only leave the sequencer when the output register can take them
  a_fin_hold : assert property (@(posedge clk) disable iff (!rst_n)
    fin_valid && !fin_take |=> fin_valid && out_valid_r)
    else $error("finished result dropped while output stalled");

endmodule

`default_nettype wire

FILE: design/ant_entry_ram.sv
`default_nettype none

module ant_entry_ram (
  input  wire logic            clk,
  input  wire ant_pkg::ram_wr_t wr,
  input  wire ant_pkg::idx_t    rd_addr,
  output ant_pkg::entry_t       rd_data
);

  ant_pkg::entry_t mem [ant_pkg::TableSlots];
  ant_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

FILE: design/ant_cmp_unit.sv
`default_nettype none

module ant_cmp_unit (
  input  wire ant_pkg::cmp_req_t req,
  input  wire logic [31:0]       age_limit,
  output logic                   hit
);

  logic [31:0] diff;

  // modular tick difference, wraps like the counter does
  assign diff = req.a - req.b;

  always_comb begin
    unique case (req.mode)
      ant_pkg::CMP_ID_EQ:  hit = (req.a == req.b);
      ant_pkg::CMP_AGE_GT: hit = (diff > age_limit);
      default:             hit = 1'b0;
    endcase
  end

endmodule

`default_nettype wire

FILE: design/ant_seq.sv
`default_nettype none

module ant_seq (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire ant_pkg::item_t    item_in,
  input  wire logic [7:0]        dist_cutoff,
  output logic                   idle,
  output ant_pkg::ram_wr_t       ram_wr,
  output ant_pkg::idx_t          ram_rd_addr,
  input  wire ant_pkg::entry_t   ram_rd_data,
  output ant_pkg::cmp_req_t      cmp_req,
  input  wire logic              cmp_hit,
  output logic                   fin_valid,
  input  wire logic              fin_take,
  output ant_pkg::result_t       result
);

  ant_pkg::state_t state_r, state_nxt;
  ant_pkg::item_t  item_r, item_nxt;
  ant_pkg::idx_t   idx_r, idx_nxt;
  ant_pkg::cnt_t   count_r, count_nxt;
  ant_pkg::cnt_t   removed_r, removed_nxt;
  logic            stored_r, stored_nxt;
  ant_pkg::entry_t new_entry;

  assign new_entry = '{id:       item_r.sender_id,
                       stamp:    item_r.now_ticks,
                       distance: item_r.distance,
                       kind:     item_r.msg_kind};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ant_pkg::ST_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r    <= item_nxt;
    idx_r     <= idx_nxt;
    removed_r <= removed_nxt;
    stored_r  <= stored_nxt;
  end

  always_comb begin
    state_nxt   = state_r;
    item_nxt    = item_r;
    idx_nxt     = idx_r;
    count_nxt   = count_r;
    removed_nxt = removed_r;
    stored_nxt  = stored_r;
    idle        = 1'b0;
    fin_valid   = 1'b0;
    ram_wr      = '{en: 1'b0, addr: idx_r, data: new_entry};
    ram_rd_addr = idx_r;
    cmp_req     = '{mode: ant_pkg::CMP_ID_EQ,
                    a:    {16'd0, item_r.sender_id},
                    b:    {16'd0, ram_rd_data.id}};

    unique case (state_r)
      ant_pkg::ST_IDLE: begin
        idle = 1'b1;
        if (start) begin
          item_nxt    = item_in;
          idx_nxt     = '0;
          stored_nxt  = 1'b0;
          removed_nxt = '0;
          unique case (item_in.opcode)
            ant_pkg::OP_MESSAGE: begin
              state_nxt = (item_in.distance > dist_cutoff) ? ant_pkg::ST_FIN
                                                           : ant_pkg::ST_MSG_RD;
            end
            ant_pkg::OP_PURGE: begin
              if (count_r == '0) begin
                state_nxt = ant_pkg::ST_FIN;
              end else begin
                idx_nxt   = count_r - 1'b1;
                state_nxt = ant_pkg::ST_PRG_RD;
              end
            end
            ant_pkg::OP_CLEAR: begin
              removed_nxt = count_r;
              count_nxt   = '0;
              state_nxt   = ant_pkg::ST_FIN;
            end
            default: state_nxt = ant_pkg::ST_FIN;
          endcase
        end
      end

      ant_pkg::ST_MSG_RD: begin
        if (idx_r == count_r) begin
          // search missed: append if a counted slot is left
          if (count_r < ant_pkg::CountMax) begin
            ram_wr     = '{en: 1'b1, addr: count_r, data: new_entry};
            count_nxt  = count_r + 1'b1;
            stored_nxt = 1'b1;
          end
          state_nxt = ant_pkg::ST_FIN;
        end else begin
          state_nxt = ant_pkg::ST_MSG_CMP;
        end
      end

      ant_pkg::ST_MSG_CMP: begin
        if (cmp_hit) begin
          ram_wr     = '{en: 1'b1, addr: idx_r, data: new_entry};
          stored_nxt = 1'b1;
          state_nxt  = ant_pkg::ST_FIN;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ant_pkg::ST_MSG_RD;
        end
      end

      ant_pkg::ST_PRG_RD: begin
        state_nxt = ant_pkg::ST_PRG_CMP;
      end

      ant_pkg::ST_PRG_CMP: begin
        cmp_req = '{mode: ant_pkg::CMP_AGE_GT,
                    a:    item_r.now_ticks,
                    b:    ram_rd_data.stamp};
        if (cmp_hit) begin
          count_nxt   = count_r - 1'b1;
          removed_nxt = removed_r + 1'b1;
        end
        if (cmp_hit && (idx_r != count_r - 1'b1)) begin
          // fetch the last entry to fill the hole
          ram_rd_addr = count_r - 1'b1;
          state_nxt   = ant_pkg::ST_PRG_MOVE;
        end else if (idx_r == '0) begin
          state_nxt = ant_pkg::ST_FIN;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = ant_pkg::ST_PRG_RD;
        end
      end

      ant_pkg::ST_PRG_MOVE: begin
        ram_wr = '{en: 1'b1, addr: idx_r, data: ram_rd_data};
        if (idx_r == '0) begin
          state_nxt = ant_pkg::ST_FIN;
        end else begin
          idx_nxt   = idx_r - 1'b1;
          state_nxt = ant_pkg::ST_PRG_RD;
        end
      end

      ant_pkg::ST_FIN: begin
        fin_valid = 1'b1;
        if (fin_take) begin
          state_nxt = ant_pkg::ST_IDLE;
        end
      end

      default: state_nxt = ant_pkg::ST_IDLE;
    endcase
  end

  assign result = '{neighbor_count: 4'(count_r),
                    stored:         stored_r,
                    removed:        4'(removed_r)};

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  // opcode the block leaves unused, and register indexes with nothing behind them
  localparam logic [1:0] OP_UNUSED       = 2'd3;
  localparam logic [7:0] REG_UNMAPPED_LO = 8'd2;
  localparam logic [7:0] REG_UNMAPPED_HI = 8'hFF;

  // bound on the whole run; this is many times what the items and the stalls on both sides need
  localparam int CycleLimit = 1_000_000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [63:0] in_tdata = '0;   // sender_id[15:0], distance[23:16],
                                // msg_kind[31:24], now_ticks[63:32]
  logic [1:0]  in_tuser = '0;   // opcode[1:0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [7:0]  out_tdata;       // neighbor_count[3:0], removed[7:4]
  logic        out_tuser;       // stored[0]
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  aging_neighbor_table u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // shadow copy of the neighbor table and its registers
  logic [15:0] nbr_id    [ant_pkg::TableSlots];
  logic [31:0] nbr_stamp [ant_pkg::TableSlots];
  logic [7:0]  nbr_dist  [ant_pkg::TableSlots];
  logic [7:0]  nbr_kind  [ant_pkg::TableSlots];
  int          nbr_count = 0;
  logic [7:0]  cutoff_shadow = ant_pkg::DIST_CUTOFF_RST;
  logic [31:0] age_limit_shadow = ant_pkg::AGE_LIMIT_RST;

  ant_pkg::result_t pending_results [$];
  ant_pkg::result_t want;
  int          errors = 0;
  int          cycles = 0;
  int          send_idle_pct = 11;
  int          recv_idle_pct = 64;

  // applies one item to the shadow table and returns the status the block should report
  function automatic ant_pkg::result_t apply_to_table(input logic [1:0] op,
                                                      input logic [15:0] id,
                                                      input logic [7:0] dist_in,
                                                      input logic [7:0] kind,
                                                      input logic [31:0] now);
    ant_pkg::result_t r;
    int          slot;
    bit          found;
    int          removed_n;
    logic [31:0] age;
    r = '0;
    slot = 0;
    found = 1'b0;
    removed_n = 0;
    case (op)
      ant_pkg::OP_MESSAGE: begin
        if (dist_in <= cutoff_shadow) begin
          for (int i = 0; i < nbr_count; i++) begin
            if (!found && nbr_id[i] == id) begin
              found = 1'b1;
              slot = i;
            end
          end
          // unknown id: append only while the table has room
          if (!found && nbr_count < ant_pkg::TableSlots - 1) begin
            slot = nbr_count;
            nbr_count++;
            found = 1'b1;
          end
          if (found) begin
            nbr_id[slot] = id;
            nbr_stamp[slot] = now;
            nbr_dist[slot] = dist_in;
            nbr_kind[slot] = kind;
            r.stored = 1'b1;
          end
        end
      end
      ant_pkg::OP_PURGE: begin
        // walk down; the last entry fills a freed slot and is not looked at again
        for (int i = nbr_count - 1; i >= 0; i--) begin
          age = now - nbr_stamp[i];
          if (age > age_limit_shadow) begin
            nbr_id[i] = nbr_id[nbr_count-1];
            nbr_stamp[i] = nbr_stamp[nbr_count-1];
            nbr_dist[i] = nbr_dist[nbr_count-1];
            nbr_kind[i] = nbr_kind[nbr_count-1];
            nbr_count--;
            removed_n++;
          end
        end
      end
      ant_pkg::OP_CLEAR: begin
        removed_n = nbr_count;
        nbr_count = 0;
      end
      default: ;
    endcase
    r.neighbor_count = 4'(nbr_count);
    r.removed = 4'(removed_n);
    return r;
  endfunction

  function automatic void check_field(input string name, input int unsigned wanted,
                                      input int unsigned got);
    if (wanted != got) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, wanted, got);
      errors++;
    end
  endfunction

  // one item transfer; valid stays up across back-to-back items
  task automatic send_item(input logic [1:0] op, input logic [15:0] id,
                           input logic [7:0] dist_in, input logic [7:0] kind,
                           input logic [31:0] now);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= {now, kind, dist_in, id};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(apply_to_table(op, id, dist_in, kind, now));
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // only called with the block idle
  task automatic write_reg(input logic [7:0] idx, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == ant_pkg::REG_DIST_CUTOFF) cutoff_shadow = data[7:0];
    else if (idx == ant_pkg::REG_AGE_LIMIT) age_limit_shadow = data;
    @(posedge clk);
  endtask

  // result side: random stalls, every transfer checked against the oldest prediction
  always @(posedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result, expected none actual count %0d stored %0d removed %0d",
                 $time, out_tdata[3:0], out_tuser, out_tdata[7:4]);
        errors++;
      end else begin
        want = pending_results.pop_front();
        check_field("neighbor_count", want.neighbor_count, out_tdata[3:0]);
        check_field("stored", want.stored, out_tuser);
        check_field("removed", want.removed, out_tdata[7:4]);
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CycleLimit) begin
      $display("aging_neighbor_table verification failed");
      $finish;
    end
  end

  // reset register values: field extremes, update, fill to full, purge with moves, clear
  task automatic test_directed_table_ops();
    send_item(ant_pkg::OP_MESSAGE, 16'h0000, 8'd0, 8'd0, 32'd0);
    send_item(ant_pkg::OP_MESSAGE, 16'hFFFF, 8'd255, 8'hFF, 32'hFFFF_FFFF);
    send_item(ant_pkg::OP_MESSAGE, 16'h0000, 8'd7, 8'h5A, 32'd300);
    send_item(OP_UNUSED, 16'($urandom()), 8'($urandom()), 8'($urandom()), $urandom());
    // odd entries stay fresh at the purge below, even ones age out
    for (int k = 0; k < 13; k++)
      send_item(ant_pkg::OP_MESSAGE, 16'h1000 + 16'(k), 8'(k * 19), 8'(k),
                k[0] ? 32'd1000 : 32'd100);
    send_item(ant_pkg::OP_MESSAGE, 16'hBEEF, 8'd3, 8'h22, 32'd1100);     // full: dropped
    send_item(ant_pkg::OP_MESSAGE, 16'hFFFF, 8'd1, 8'h11, 32'd1150);     // full but known
    send_item(ant_pkg::OP_PURGE, 16'($urandom()), 8'($urandom()), 8'($urandom()), 32'd1200);
    send_item(ant_pkg::OP_PURGE, 16'($urandom()), 8'($urandom()), 8'($urandom()), 32'd1200);
    send_item(ant_pkg::OP_CLEAR, 16'($urandom()), 8'($urandom()), 8'($urandom()), $urandom());
    send_item(ant_pkg::OP_CLEAR, 16'($urandom()), 8'($urandom()), 8'($urandom()), $urandom());
    send_item(ant_pkg::OP_PURGE, 16'($urandom()), 8'($urandom()), 8'($urandom()), $urandom());
    drain_results();
  endtask

  // cutoff edge, zero age limit, and writes to indexes that map to nothing
  task automatic test_cutoff_and_registers();
    write_reg(ant_pkg::REG_DIST_CUTOFF, 32'd100);
    write_reg(ant_pkg::REG_AGE_LIMIT, 32'd0);
    write_reg(REG_UNMAPPED_LO, 32'd0);
    write_reg(REG_UNMAPPED_HI, 32'hFFFF_FFFF);
    send_item(ant_pkg::OP_MESSAGE, 16'h00AA, 8'd101, 8'h01, 32'd5000);   // over cutoff
    send_item(ant_pkg::OP_MESSAGE, 16'h00AA, 8'd100, 8'h02, 32'd5000);
    send_item(ant_pkg::OP_MESSAGE, 16'h00AB, 8'd255, 8'h03, 32'd5000);   // over cutoff
    send_item(ant_pkg::OP_PURGE, 16'h0, 8'd0, 8'd0, 32'd5000);           // age 0, kept
    send_item(ant_pkg::OP_PURGE, 16'h0, 8'd0, 8'd0, 32'd5001);           // age 1, removed
    drain_results();
  endtask

  // mostly messages from a small id pool so hits and a full table are frequent
  task automatic test_random_traffic(input int n_items, input logic [7:0] cutoff,
                                     input logic [31:0] age, input int tx_idle,
                                     input int rx_idle);
    logic [15:0] id_pool [20];
    logic [31:0] tick;
    logic [1:0]  op;
    logic [15:0] id;
    logic [7:0]  est_dist;
    int          pick;
    write_reg(ant_pkg::REG_DIST_CUTOFF, 32'(cutoff));
    write_reg(ant_pkg::REG_AGE_LIMIT, age);
    send_idle_pct = tx_idle;
    recv_idle_pct = rx_idle;
    foreach (id_pool[k]) id_pool[k] = 16'($urandom());
    tick = $urandom();
    repeat (n_items) begin
      pick = $urandom_range(0, 99);
      if (pick < 78) op = ant_pkg::OP_MESSAGE;
      else if (pick < 94) op = ant_pkg::OP_PURGE;
      else if (pick < 98) op = ant_pkg::OP_CLEAR;
      else op = OP_UNUSED;
      if ($urandom_range(0, 9) == 0) id = 16'($urandom());
      else id = id_pool[$urandom_range(0, 19)];
      if ($urandom_range(0, 9) < 8) est_dist = 8'($urandom_range(0, cutoff));
      else est_dist = 8'($urandom());
      // time mostly creeps forward; sometimes jumps anywhere, wrap included
      if ($urandom_range(0, 29) == 0) tick = $urandom();
      else tick = tick + $urandom_range(0, 120);
      send_item(op, id, est_dist, 8'($urandom()), tick);
    end
    drain_results();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_table_ops();
    test_cutoff_and_registers();
    test_random_traffic(225, 8'd255, 32'd248, 11, 64);
    test_random_traffic(225, 8'd0, 32'd0, 11, 64);
    test_random_traffic(225, 8'd200, 32'hFFFF_FFFF, 64, 11);
    test_random_traffic(225, 8'd128, 32'd1000, 64, 11);
    test_random_traffic(225, 8'($urandom()), $urandom_range(0, 400), 0, 0);
    test_random_traffic(225, 8'd255, 32'd60, 0, 0);
    repeat (64) @(posedge clk);
    if (errors == 0) begin
      $display("aging_neighbor_table verification clean");
    end else begin
      $display("aging_neighbor_table verification failed");
    end
    $finish;
  end

endmodule
